// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files; the positioner core includes them.
// Each expects a clock named clk in scope; MSP_ASSERT also expects a synchronous reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define MSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define MSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Types, constants and the speed table of the multi-arm stepper positioner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

  localparam int unsigned CLOCK_COUNT_DEF      = 4;
  localparam int unsigned STEPS_PER_DEGREE_DEF = 12;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned TARGET_W = 8;
  localparam int unsigned ANGLE_W  = 9;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OUT_W    = 8;
  localparam int unsigned STEP_W   = 13;
  localparam int unsigned WAIT_W   = 13;
  localparam int unsigned SPEED_W  = 3;
  localparam int unsigned PROD_W   = 16;
  localparam int unsigned DIFF_W   = 11;

  localparam logic [TARGET_W-1:0] START_CODE = 8'd200;
  localparam logic [SPEED_W-1:0]  SPEED_MAX  = 3'd5;
  localparam logic [SPEED_W-1:0]  SPEED_RST  = 3'd1;
  localparam logic [STEP_W-1:0]   STEP_MAX   = 13'd8191;
  localparam logic [DIFF_W-1:0]   DEG_FULL   = 11'd360;
  localparam logic [DIFF_W-1:0]   DEG_TWO    = 11'd720;
  localparam logic [DIFF_W-1:0]   DEG_THREE  = 11'd1080;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_POS   = 2'd1,
    KIND_SPEED = 2'd2,
    KIND_START = 2'd3
  } kind_t;

  typedef enum logic {
    OP_CALC  = 1'b0,
    OP_SERVE = 1'b1
  } arm_op_t;

  typedef struct packed {
    logic [STEP_W-1:0] steps;
    logic              done;
    logic              snap;
    logic              pulse;
  } arm_res_t;

  function automatic logic [WAIT_W-1:0] speed_wait(input logic [SPEED_W-1:0] si);
    logic [WAIT_W-1:0] w;
    unique case (si)
      3'd0:    w = 13'd100;
      3'd1:    w = 13'd200;
      3'd2:    w = 13'd500;
      3'd3:    w = 13'd1000;
      3'd4:    w = 13'd2500;
      default: w = 13'd5000;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/msp_in_if.sv =====
// ----------------------------------------------------------------------------
// msp_in_if
// Command and tick channel: valid, ready and one input item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface msp_in_if;
  logic                          valid;
  logic                          ready;
  logic [msp_pkg::KIND_W-1:0]    kind;
  logic [msp_pkg::TARGET_W-1:0]  target;
  logic [msp_pkg::ANGLE_W-1:0]   minute_angle;
  logic [msp_pkg::ANGLE_W-1:0]   hour_angle;
  logic [msp_pkg::BYTE_W-1:0]    minute_speed;
  logic [msp_pkg::BYTE_W-1:0]    minute_dir;
  logic [msp_pkg::BYTE_W-1:0]    hour_dir;

  modport source (
    output valid, kind, target, minute_angle, hour_angle, minute_speed,
           minute_dir, hour_dir,
    input  ready
  );

  modport sink (
    input  valid, kind, target, minute_angle, hour_angle, minute_speed,
           minute_dir, hour_dir,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/msp_out_if.sv =====
// ----------------------------------------------------------------------------
// msp_out_if
// Status channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface msp_out_if;
  logic                       valid;
  logic                       ready;
  logic [msp_pkg::OUT_W-1:0]  step_pulses;
  logic [msp_pkg::OUT_W-1:0]  dir_levels;
  logic                       moving;
  logic [msp_pkg::OUT_W-1:0]  arms_at_position;

  modport source (
    output valid, step_pulses, dir_levels, moving, arms_at_position,
    input  ready
  );

  modport sink (
    input  valid, step_pulses, dir_levels, moving, arms_at_position,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/msp_arm_unit.sv =====
// ----------------------------------------------------------------------------
// msp_arm_unit
// Shared arm arithmetic: forward step count at start, count-down on a pulse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msp_arm_unit #(
  parameter int unsigned STEPS_PER_DEGREE = msp_pkg::STEPS_PER_DEGREE_DEF
) (
  input  var msp_pkg::arm_op_t                 op,
  input  var logic [msp_pkg::ANGLE_W-1:0]      want,
  input  var logic [msp_pkg::ANGLE_W-1:0]      have,
  input  var logic [msp_pkg::STEP_W-1:0]       steps,
  input  var logic                             done,
  output msp_pkg::arm_res_t                    res
);

  logic [msp_pkg::DIFF_W-1:0]  diff_raw;
  logic [msp_pkg::DIFF_W-1:0]  diff_mod;
  logic [msp_pkg::PROD_W-1:0]  prod;
  logic [msp_pkg::STEP_W-1:0]  fwd_steps;
  logic [msp_pkg::STEP_W-1:0]  dec_steps;

  always_comb begin
    diff_raw = msp_pkg::DIFF_W'(want) + msp_pkg::DEG_TWO - msp_pkg::DIFF_W'(have);
    priority if (diff_raw >= msp_pkg::DEG_THREE) begin
      diff_mod = diff_raw - msp_pkg::DEG_THREE;
    end else if (diff_raw >= msp_pkg::DEG_TWO) begin
      diff_mod = diff_raw - msp_pkg::DEG_TWO;
    end else if (diff_raw >= msp_pkg::DEG_FULL) begin
      diff_mod = diff_raw - msp_pkg::DEG_FULL;
    end else begin
      diff_mod = diff_raw;
    end
    prod = msp_pkg::PROD_W'(diff_mod) * msp_pkg::PROD_W'(STEPS_PER_DEGREE);
    fwd_steps = (prod > msp_pkg::PROD_W'(msp_pkg::STEP_MAX)) ? msp_pkg::STEP_MAX
                                                              : prod[msp_pkg::STEP_W-1:0];
    dec_steps = (steps != '0) ? steps - 1'b1 : steps;

    unique case (op)
      msp_pkg::OP_CALC: begin
        res.steps = fwd_steps;
        res.done  = (fwd_steps == '0);
        res.snap  = 1'b0;
        res.pulse = 1'b0;
      end
      msp_pkg::OP_SERVE: begin
        if (done) begin
          res.steps = steps;
          res.done  = 1'b1;
          res.snap  = 1'b0;
          res.pulse = 1'b0;
        end else begin
          res.steps = dec_steps;
          res.done  = (dec_steps == '0);
          res.snap  = (dec_steps == '0);
          res.pulse = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/multi_arm_stepper_positioner_core.sv =====
// ----------------------------------------------------------------------------
// multi_arm_stepper_positioner_core
// Positions two arms on each of several dials; one shared arm unit is stepped
// over the arms by a small sequencer.
// ----------------------------------------------------------------------------
// Channel  Dir  Item
// cmd      in   kind, target, minute_angle, hour_angle, minute_speed, dirs
// status   out  step_pulses, dir_levels, moving, arms_at_position
//
// Position, speed and ignored commands go from idle straight to finish. Tick:
// the same, or, when a clock is served, two arm-unit passes and a round update.
// Start: one arm-unit pass per arm. cmd is ready only in the idle state.
// A finished result waits in the status register; the next item is taken
// meanwhile and its result held until status drains. rst is synchronous.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module multi_arm_stepper_positioner_core #(
  parameter int unsigned CLOCK_COUNT      = msp_pkg::CLOCK_COUNT_DEF,
  parameter int unsigned STEPS_PER_DEGREE = msp_pkg::STEPS_PER_DEGREE_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  msp_in_if.sink      cmd,
  msp_out_if.source   status
);

  localparam int unsigned ARM_COUNT = 2 * CLOCK_COUNT;
  localparam int unsigned CW = (CLOCK_COUNT > 1) ? $clog2(CLOCK_COUNT) : 1;
  localparam int unsigned AW = $clog2(ARM_COUNT);
  localparam int unsigned OB = (ARM_COUNT < msp_pkg::OUT_W) ? ARM_COUNT : msp_pkg::OUT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SERVE,
    ST_ROUND,
    ST_FINISH
  } state_t;

  state_t                        state;
  logic [AW-1:0]                 arm_idx;
  logic [msp_pkg::ANGLE_W-1:0]   current_angle [ARM_COUNT];
  logic [msp_pkg::ANGLE_W-1:0]   desired_angle [ARM_COUNT];
  logic [msp_pkg::STEP_W-1:0]    steps_left    [ARM_COUNT];
  logic [ARM_COUNT-1:0]          arm_done;
  logic [ARM_COUNT-1:0]          dir_level;
  logic [ARM_COUNT-1:0]          pulsed;
  logic [msp_pkg::SPEED_W-1:0]   speed_index   [CLOCK_COUNT];
  logic                          move_active;
  logic [CW-1:0]                 clock_pointer;
  logic [msp_pkg::WAIT_W-1:0]    wait_count;
  logic                          round_had_pulse;

  msp_pkg::arm_op_t              unit_op;
  msp_pkg::arm_res_t             unit_res;
  logic                          cmd_fire;
  logic                          clock_hit;
  logic [CW-1:0]                 cmd_clock;
  logic                          round_next;
  logic [ARM_COUNT-1:0]          zero_steps;

  assign cmd.ready  = (state == ST_IDLE);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign clock_hit  = (cmd.target < msp_pkg::TARGET_W'(CLOCK_COUNT));
  assign cmd_clock  = cmd.target[CW-1:0];
  assign unit_op    = (state == ST_CALC) ? msp_pkg::OP_CALC : msp_pkg::OP_SERVE;
  assign round_next = round_had_pulse || (pulsed != '0);

  msp_arm_unit #(
    .STEPS_PER_DEGREE (STEPS_PER_DEGREE)
  ) u_arm (
    .op    (unit_op),
    .want  (desired_angle[arm_idx]),
    .have  (current_angle[arm_idx]),
    .steps (steps_left[arm_idx]),
    .done  (arm_done[arm_idx]),
    .res   (unit_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      arm_idx         <= '0;
      arm_done        <= '1;
      dir_level       <= '0;
      pulsed          <= '0;
      move_active     <= 1'b0;
      clock_pointer   <= '0;
      wait_count      <= '0;
      round_had_pulse <= 1'b0;
      status.valid    <= 1'b0;
      for (int a = 0; a < ARM_COUNT; a++) begin
        current_angle[a] <= '0;
        desired_angle[a] <= '0;
        steps_left[a]    <= '0;
      end
      for (int c = 0; c < CLOCK_COUNT; c++) begin
        speed_index[c] <= msp_pkg::SPEED_RST;
      end
    end else begin
      if (status.valid && status.ready && state != ST_FINISH) begin
        status.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            pulsed <= '0;
            unique case (msp_pkg::kind_t'(cmd.kind))
              msp_pkg::KIND_POS: begin
                if (clock_hit) begin
                  desired_angle[AW'({cmd_clock, 1'b0})] <= cmd.minute_angle;
                  desired_angle[AW'({cmd_clock, 1'b1})] <= cmd.hour_angle;
                end
                state <= ST_FINISH;
              end
              msp_pkg::KIND_SPEED: begin
                if (clock_hit) begin
                  speed_index[cmd_clock] <=
                    (cmd.minute_speed > msp_pkg::BYTE_W'(msp_pkg::SPEED_MAX))
                      ? msp_pkg::SPEED_MAX : cmd.minute_speed[msp_pkg::SPEED_W-1:0];
                  dir_level[AW'({cmd_clock, 1'b0})] <= (cmd.minute_dir != '0);
                  dir_level[AW'({cmd_clock, 1'b1})] <= (cmd.hour_dir != '0);
                end
                state <= ST_FINISH;
              end
              msp_pkg::KIND_START: begin
                if (cmd.target == msp_pkg::START_CODE) begin
                  arm_idx <= '0;
                  state   <= ST_CALC;
                end else begin
                  state <= ST_FINISH;
                end
              end
              msp_pkg::KIND_TICK: begin
                if (move_active && wait_count == '0) begin
                  arm_idx <= AW'({clock_pointer, 1'b0});
                  state   <= ST_SERVE;
                end else begin
                  if (move_active) begin
                    wait_count <= wait_count - 1'b1;
                  end
                  state <= ST_FINISH;
                end
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_CALC: begin
          steps_left[arm_idx] <= unit_res.steps;
          arm_done[arm_idx]   <= unit_res.done;
          if (arm_idx == AW'(ARM_COUNT - 1)) begin
            move_active     <= 1'b1;
            clock_pointer   <= '0;
            wait_count      <= '0;
            round_had_pulse <= 1'b0;
            state           <= ST_FINISH;
          end else begin
            arm_idx <= arm_idx + 1'b1;
          end
        end
        ST_SERVE: begin
          steps_left[arm_idx] <= unit_res.steps;
          arm_done[arm_idx]   <= unit_res.done;
          pulsed[arm_idx]     <= unit_res.pulse;
          if (unit_res.snap) begin
            current_angle[arm_idx] <= desired_angle[arm_idx];
          end
          if (arm_idx[0]) begin
            state <= ST_ROUND;
          end else begin
            arm_idx <= arm_idx + 1'b1;
          end
        end
        ST_ROUND: begin
          if (clock_pointer == CW'(CLOCK_COUNT - 1)) begin
            clock_pointer   <= '0;
            round_had_pulse <= 1'b0;
            if (!round_next) begin
              move_active <= 1'b0;
              wait_count  <= '0;
            end else begin
              wait_count <= msp_pkg::speed_wait(speed_index[clock_pointer]);
            end
          end else begin
            wait_count      <= msp_pkg::speed_wait(speed_index[clock_pointer]);
            clock_pointer   <= clock_pointer + 1'b1;
            round_had_pulse <= round_next;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!status.valid || status.ready) begin
            status.valid            <= 1'b1;
            status.step_pulses      <= msp_pkg::OUT_W'(pulsed[OB-1:0]);
            status.dir_levels       <= msp_pkg::OUT_W'(dir_level[OB-1:0]);
            status.moving           <= move_active;
            status.arms_at_position <= msp_pkg::OUT_W'(arm_done[OB-1:0]);
            state                   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < ARM_COUNT; a++) begin
      zero_steps[a] = (steps_left[a] == '0);
    end
  end

  `MSP_ASSERT(a_done_matches_count, arm_done == zero_steps, "arm done flag and step count disagree")
  `MSP_ASSERT(a_serve_only_when_due, (state == ST_SERVE) |-> (move_active && wait_count == '0), "arm served while idle or waiting")
  `MSP_ASSERT(a_idle_no_wait, (state == ST_IDLE && !move_active) |-> (wait_count == '0), "wait pending with no move")
  `MSP_ASSERT(a_busy_after_accept, cmd_fire |=> !cmd.ready, "item accepted while previous item in work")

endmodule

`default_nettype wire
